// ----- src/cau_pkg.sv -----
// Shared types and constants for the complex arithmetic unit.
// No dependencies; imported by cau_div_cell, complex_arithmetic_unit and the testbench.
`default_nettype none
package cau_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // control flags that ride along the divider chain with each beat
  typedef struct packed {
    logic valid;
    logic div;
    logic dz;
    logic big_re;
    logic big_im;
    logic neg_re;
    logic neg_im;
  } cau_flags_t;

endpackage
`default_nettype wire

// ----- src/complex_arithmetic_unit.sv -----
// Complex ALU (add, subtract, multiply, divide) on signed fixed point.
// Pipeline: input, product, sum and prepare stages, a chain
// of DATA_WIDTH + 1 divider cells (one quotient bit each) and the output register.
// Throughput one beat per cycle; the whole pipeline holds while the output waits.
// Synchronous active-high reset empties the pipeline; payload is not cleared.
`default_nettype none
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // a_re, a_im, b_re, b_im from bit 0 up, zero padded to bytes
  input  wire  [((4*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // command
  input  wire  [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // res_re, res_im from bit 0 up, zero padded to bytes
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  // overflow, div_zero from bit 0 up
  output logic [1:0]                           m_axis_tuser
);
  import cau_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int QB  = W + 1;
  localparam int MW  = 2*W + 1;
  localparam int DW  = 2*W;
  localparam int RW  = 3*W + F + 1;
  localparam int OTW = ((2*W+7)/8)*8;

  logic en;

  // stage 0: operands
  logic                v0;
  logic [1:0]          cmd0;
  logic signed [W-1:0] ar0, ai0, br0, bi0;

  // stage 1: products and short sums
  logic                  v1;
  logic [1:0]            cmd1;
  logic signed [2*W-1:0] p_ac, p_bd, p_ad, p_bc, p_cc, p_dd;
  logic signed [W:0]     s_re1, s_im1;

  // stage 2: combined terms
  logic                  v2;
  logic [1:0]            cmd2;
  logic signed [2*W:0]   t_re2, t_im2;
  logic [DW-1:0]         den2;

  // stage 3 combinational
  logic [MW-1:0] mag_re, mag_im, side_re, side_im;
  logic [RW-1:0] dvd_re, dvd_im, dlim;

  // chain taps
  cau_flags_t      fl   [0:QB];
  logic [DW-1:0]   dn   [0:QB];
  logic [RW-1:0]   rr   [0:QB];
  logic [RW-1:0]   ri   [0:QB];
  logic [QB-1:0]   qr   [0:QB];
  logic [QB-1:0]   qi   [0:QB];
  logic [2*MW-1:0] sd   [0:QB];

  // output stage combinational
  logic [MW-1:0]  fm_re, fm_im;
  logic [W-1:0]   o_re, o_im;
  logic           ov_re, ov_im;
  logic [MW-1:0]  lim_pos, lim_neg;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      fl[0].valid <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
      fl[0].valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0 <= s_axis_tuser;
      ar0  <= s_axis_tdata[W-1:0];
      ai0  <= s_axis_tdata[2*W-1:W];
      br0  <= s_axis_tdata[3*W-1:2*W];
      bi0  <= s_axis_tdata[4*W-1:3*W];

      cmd1 <= cmd0;
      p_ac <= (2*W)'(ar0) * (2*W)'(br0);
      p_bd <= (2*W)'(ai0) * (2*W)'(bi0);
      p_ad <= (2*W)'(ar0) * (2*W)'(bi0);
      p_bc <= (2*W)'(ai0) * (2*W)'(br0);
      p_cc <= (2*W)'(br0) * (2*W)'(br0);
      p_dd <= (2*W)'(bi0) * (2*W)'(bi0);
      if (cmd0 == CMD_SUB) begin
        s_re1 <= {ar0[W-1], ar0} - {br0[W-1], br0};
        s_im1 <= {ai0[W-1], ai0} - {bi0[W-1], bi0};
      end else begin
        s_re1 <= {ar0[W-1], ar0} + {br0[W-1], br0};
        s_im1 <= {ai0[W-1], ai0} + {bi0[W-1], bi0};
      end

      cmd2 <= cmd1;
      den2 <= DW'(p_cc) + DW'(p_dd);
      unique case (cmd1)
        CMD_ADD, CMD_SUB: begin
          t_re2 <= {{W{s_re1[W]}}, s_re1};
          t_im2 <= {{W{s_im1[W]}}, s_im1};
        end
        CMD_MUL: begin
          t_re2 <= {p_ac[2*W-1], p_ac} - {p_bd[2*W-1], p_bd};
          t_im2 <= {p_ad[2*W-1], p_ad} + {p_bc[2*W-1], p_bc};
        end
        default: begin
          t_re2 <= {p_ac[2*W-1], p_ac} + {p_bd[2*W-1], p_bd};
          t_im2 <= {p_bc[2*W-1], p_bc} - {p_ad[2*W-1], p_ad};
        end
      endcase
    end
  end

  // stage 3: sign-magnitude form, dividend and quotient range check
  always_comb begin
    mag_re  = t_re2[2*W] ? MW'(-t_re2) : MW'(t_re2);
    mag_im  = t_im2[2*W] ? MW'(-t_im2) : MW'(t_im2);
    side_re = (cmd2 == CMD_MUL) ? (mag_re >> F) : mag_re;
    side_im = (cmd2 == CMD_MUL) ? (mag_im >> F) : mag_im;
    dvd_re  = RW'(mag_re) << F;
    dvd_im  = RW'(mag_im) << F;
    dlim    = RW'(den2) << QB;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0].div    <= (cmd2 == CMD_DIV);
      fl[0].dz     <= (cmd2 == CMD_DIV) && (den2 == '0);
      fl[0].big_re <= dvd_re >= dlim;
      fl[0].big_im <= dvd_im >= dlim;
      fl[0].neg_re <= t_re2[2*W];
      fl[0].neg_im <= t_im2[2*W];
      dn[0]        <= den2;
      rr[0]        <= dvd_re;
      ri[0]        <= dvd_im;
      qr[0]        <= '0;
      qi[0]        <= '0;
      sd[0]        <= {side_im, side_re};
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_cell
    cau_div_cell #(
      .RW    (RW),
      .DW    (DW),
      .QW    (QB),
      .MW    (MW),
      .SHIFT (QB - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .flags_in  (fl[k]),
      .den_in    (dn[k]),
      .rem_re_in (rr[k]),
      .rem_im_in (ri[k]),
      .q_re_in   (qr[k]),
      .q_im_in   (qi[k]),
      .side_in   (sd[k]),
      .flags     (fl[k+1]),
      .den       (dn[k+1]),
      .rem_re    (rr[k+1]),
      .rem_im    (ri[k+1]),
      .q_re      (qr[k+1]),
      .q_im      (qi[k+1]),
      .side      (sd[k+1])
    );
  end

  // saturation
  always_comb begin
    lim_pos = (MW'(1) << (W-1)) - MW'(1);
    lim_neg = MW'(1) << (W-1);
    if (fl[QB].div) begin
      fm_re = fl[QB].big_re ? '1 : MW'(qr[QB]);
      fm_im = fl[QB].big_im ? '1 : MW'(qi[QB]);
    end else begin
      fm_re = sd[QB][MW-1:0];
      fm_im = sd[QB][2*MW-1:MW];
    end
    if (fl[QB].neg_re) begin
      ov_re = fm_re > lim_neg;
      o_re  = ov_re ? W'(-lim_neg) : W'(-fm_re);
    end else begin
      ov_re = fm_re > lim_pos;
      o_re  = ov_re ? W'(lim_pos) : W'(fm_re);
    end
    if (fl[QB].neg_im) begin
      ov_im = fm_im > lim_neg;
      o_im  = ov_im ? W'(-lim_neg) : W'(-fm_im);
    end else begin
      ov_im = fm_im > lim_pos;
      o_im  = ov_im ? W'(lim_pos) : W'(fm_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= fl[QB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl[QB].dz) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 2'b10;
      end else begin
        m_axis_tdata <= OTW'({o_im, o_re});
        m_axis_tuser <= {1'b0, ov_re || ov_im};
      end
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
    else $error("divide by zero beat carries data or overflow");

  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[W-1:0] == W'(lim_pos) || m_axis_tdata[W-1:0] == W'(-lim_neg) ||
       m_axis_tdata[2*W-1:W] == W'(lim_pos) || m_axis_tdata[2*W-1:W] == W'(-lim_neg)))
    else $error("overflow flagged without a saturated part");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(fl[QB].valid) && $stable(qr[QB]))
    else $error("divider chain moved during output stall");

endmodule
`default_nettype wire

// ----- src/cau_div_cell.sv -----
// One restoring-division cell: settles one quotient bit for both lanes.
// Depends on cau_pkg for the flag struct.
`default_nettype none
module cau_div_cell #(
  parameter int RW    = 57,
  parameter int DW    = 32,
  parameter int QW    = 17,
  parameter int MW    = 33,
  parameter int SHIFT = 0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  cau_pkg::cau_flags_t flags_in,
  input  wire  [DW-1:0]       den_in,
  input  wire  [RW-1:0]       rem_re_in,
  input  wire  [RW-1:0]       rem_im_in,
  input  wire  [QW-1:0]       q_re_in,
  input  wire  [QW-1:0]       q_im_in,
  input  wire  [2*MW-1:0]     side_in,
  output cau_pkg::cau_flags_t flags,
  output logic [DW-1:0]       den,
  output logic [RW-1:0]       rem_re,
  output logic [RW-1:0]       rem_im,
  output logic [QW-1:0]       q_re,
  output logic [QW-1:0]       q_im,
  output logic [2*MW-1:0]     side
);
  import cau_pkg::*;

  logic [RW-1:0] dsh;
  logic          fit_re, fit_im;
  logic [RW-1:0] rem_re_next, rem_im_next;

  always_comb begin
    dsh         = RW'(den_in) << SHIFT;
    fit_re      = rem_re_in >= dsh;
    fit_im      = rem_im_in >= dsh;
    rem_re_next = fit_re ? rem_re_in - dsh : rem_re_in;
    rem_im_next = fit_im ? rem_im_in - dsh : rem_im_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags.valid <= 1'b0;
    end else if (en) begin
      flags.valid <= flags_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags.div    <= flags_in.div;
      flags.dz     <= flags_in.dz;
      flags.big_re <= flags_in.big_re;
      flags.big_im <= flags_in.big_im;
      flags.neg_re <= flags_in.neg_re;
      flags.neg_im <= flags_in.neg_im;
      den          <= den_in;
      rem_re       <= rem_re_next;
      rem_im       <= rem_im_next;
      q_re         <= {q_re_in[QW-2:0], fit_re};
      q_im         <= {q_im_in[QW-2:0], fit_im};
      side         <= side_in;
    end
  end

endmodule
`default_nettype wire

// ----- tb/complex_arithmetic_unit_chk.sv -----
// Checker for the complex arithmetic unit: watches both stream channels,
// predicts each result from the accepted operands and compares. Uses cau_pkg.
module complex_arithmetic_unit_chk (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [63:0] s_axis_tdata,
  input  wire  [1:0]  s_axis_tuser,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [31:0] m_axis_tdata,
  input  wire  [1:0]  m_axis_tuser,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  import cau_pkg::*;

  typedef struct packed {
    logic        div_zero;
    logic        overflow;
    logic [15:0] res_im;
    logic [15:0] res_re;
  } cau_result_t;

  cau_result_t expected_q[$];

  // clamp a wide signed value to Q8.8, noting saturation
  function automatic logic [15:0] clamp16(input logic signed [47:0] v, inout logic ovf);
    if (v > 48'sd32767) begin
      ovf = 1'b1;
      return 16'h7fff;
    end else if (v < -48'sd32768) begin
      ovf = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // truncating division toward zero of (num << 8) / den
  function automatic logic signed [47:0] qdiv(input logic signed [47:0] num,
                                              input logic signed [47:0] den);
    logic signed [47:0] mag;
    logic signed [47:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< 8) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cau_result_t complex_op(input logic [1:0] cmd, input logic [63:0] d);
    logic signed [47:0] a, b, c, e, re, im, den;
    cau_result_t r;
    logic ovf;
    a = 48'($signed(d[15:0]));
    b = 48'($signed(d[31:16]));
    c = 48'($signed(d[47:32]));
    e = 48'($signed(d[63:48]));
    ovf = 1'b0;
    r = '0;
    case (cmd)
      CMD_ADD: begin
        re = a + c;
        im = b + e;
      end
      CMD_SUB: begin
        re = a - c;
        im = b - e;
      end
      CMD_MUL: begin
        re = a * c - b * e;
        im = a * e + b * c;
        re = (re < 0) ? -((-re) >>> 8) : re >>> 8;
        im = (im < 0) ? -((-im) >>> 8) : im >>> 8;
      end
      default: begin
        den = c * c + e * e;
        if (den == 0) begin
          r.div_zero = 1'b1;
          return r;
        end
        re = qdiv(a * c + b * e, den);
        im = qdiv(b * c - a * e, den);
      end
    endcase
    r.res_re = clamp16(re, ovf);
    r.res_im = clamp16(im, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    cau_result_t want, got;
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(complex_op(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[1], m_axis_tuser[0], m_axis_tdata[31:16], m_axis_tdata[15:0]};
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result beat %h", got);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== got) begin
            if (errors < 10)
              $display("mismatch: exp re %h im %h ovf %b dz %b, got re %h im %h ovf %b dz %b",
                       want.res_re, want.res_im, want.overflow, want.div_zero,
                       got.res_re, got.res_im, got.overflow, got.div_zero);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/complex_arithmetic_unit_tb.sv -----
// Testbench top for the complex arithmetic unit: clock, reset, operand stimulus
// with random idling, and the verdict. Needs cau_pkg and the checker module.
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // a_re, a_im, b_re, b_im from bit 0 up
  logic [1:0]  s_axis_tuser = '0;  // command
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [31:0] m_axis_tdata;       // res_re, res_im from bit 0 up
  wire  [1:0]  m_axis_tuser;       // overflow, div_zero from bit 0 up
  int          errors, pending, results_seen, cycles;
  int          sink_idle_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  complex_arithmetic_unit i_dut (.*);
  complex_arithmetic_unit_chk i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("complex_arithmetic_unit_tb: FAIL");
      $finish;
    end
  end
  initial cycles = 0;

  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // present one beat, holding it until accepted, with random gaps before it
  task automatic send_beat(input logic [1:0] cmd, input logic [63:0] data, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin
    logic [15:0] corner[4];
    logic [63:0] d;
    int src_idle;
    corner = '{16'h7fff, 16'h8000, 16'h0000, 16'h0100};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes across every command, zero divisor, unit operands
    for (int k = 0; k < 4; k++) begin
      for (int m = 0; m < 4; m++)
        send_beat(2'(k), {corner[m], corner[3 - m], corner[m], corner[(m + 1) % 4]}, 0);
      send_beat(2'(k), {16'h0000, 16'h0000, 16'hffff, 16'h0001}, 0);
    end
    send_beat(CMD_DIV, {16'h0001, 16'h0000, 16'h7fff, 16'h7fff}, 0);
    send_beat(CMD_DIV, {16'h0000, 16'h0001, 16'h8000, 16'h8000}, 0);
    send_beat(CMD_MUL, {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 0);
    for (int p = 0; p < 3; p++) begin
      src_idle = (p == 0) ? 20 : (p == 1) ? 87 : 0;
      sink_idle_pct <= (p == 0) ? 87 : (p == 1) ? 20 : 0;
      for (int n = 0; n < 410; n++) begin
        d = {pick_operand(), pick_operand(), pick_operand(), pick_operand()};
        send_beat(2'($urandom_range(3)), d, src_idle);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d results over add, subtract, multiply and divide,", results_seen);
    $display("with operand extremes, zero divisors and idling on both channels");
    if (errors == 0 && pending == 0)
      $display("complex_arithmetic_unit_tb: PASS");
    else
      $display("complex_arithmetic_unit_tb: FAIL");
    $finish;
  end
endmodule
